// ===== design/spq_pkg.sv =====
package spq_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int KEY_W    = 32;
  localparam int COUNT_W  = 5;

  typedef logic signed [KEY_W-1:0] key_t;

  typedef enum logic [1:0] {
    CMD_INSERT  = 2'd0,
    CMD_DEQUEUE = 2'd1,
    CMD_PEEK    = 2'd2,
    CMD_INC_KEY = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_NEG   = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  typedef struct packed {
    cmd_e command;
    key_t key;
    key_t amount;
  } in_t;

  typedef struct packed {
    key_t               value;
    status_e            status;
    logic [COUNT_W-1:0] count;
  } out_t;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

endpackage

// ===== design/spq_cell.sv =====
module spq_cell import spq_pkg::*; (
  input  logic       clk_i,
  input  cell_ctrl_t ctrl_i,
  input  key_t       right_i,
  input  key_t       load_data_i,
  output key_t       entry_o
);

  key_t entry_q;
  key_t entry_d;

  always_comb begin
    priority if (ctrl_i.load) begin
      entry_d = load_data_i;
    end else if (ctrl_i.shift) begin
      entry_d = right_i;
    end else begin
      entry_d = entry_q;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

// ===== design/sorted_priority_queue_core.sv =====
// Sorted priority queue of signed Q16.16 keys, up to CAPACITY entries.
// Input channel: in_valid_i / in_stall_o with payload in_i (command, key,
// amount). A transaction is taken when valid is high and stall is low.
// Output channel: out_valid_o / out_stall_i with payload out_o (value,
// status, count); exactly one result per input transaction.
// Config: cfg_we_i / cfg_wdata_i write order_mode (0 largest first,
// 1 smallest first); write only while idle.
// Peek, dequeue, a negative amount and an insert into a full queue go
// straight to the result stage. Insert makes one pass in which the
// entries are rotated through the chain of cells one entry per cycle,
// past the compare at the head cell; an insert that lands ahead of a held
// entry adds a step that loads the key without rotating. Increase-key first
// makes a removal pass, then reports full if the queue stays full, else
// makes an insert pass with the new key. One command is in flight at a time.
// The input side is open again as soon as the result sits in the output
// register, even if that result is still stalled.
// Reset empties the queue, clears out_valid_o and sets order_mode to 0.
// While out_stall_i holds a result, the next finished result waits in an
// internal stage and the input stays stalled until it moves out.
module sorted_priority_queue_core import spq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic cfg_wdata_i,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_REM  = 2'd1;
  localparam logic [1:0] S_INS  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [CNT_W-1:0] held_q, held_d;
  logic [CNT_W-1:0] rem_q, rem_d;
  logic             ins_q, ins_d;
  logic             mode_q;
  key_t             key_q, key_d;
  key_t             nk_q, nk_d;
  out_t             res_q, res_d;
  out_t             out_q, out_d;
  logic             out_valid_q, out_valid_d;

  key_t             entry [CAPACITY];
  key_t             right [CAPACITY];
  cell_ctrl_t       ctrl  [CAPACITY];
  key_t             head;
  key_t             load_data;
  logic             shift_all, load_all, load_key;
  logic [CNT_W-1:0] load_pos;
  logic signed [KEY_W:0] adj_sum;
  key_t             adj_key;

  function automatic logic goes_before(input logic mode, input key_t a, input key_t b);
    goes_before = mode ? (a < b) : (a > b);
  endfunction

  assign head      = entry[0];
  assign load_data = load_key ? key_q : head;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == CAPACITY - 1) begin : g_last
      assign right[i] = entry[i];
    end else begin : g_mid
      assign right[i] = entry[i+1];
    end
    assign ctrl[i] = '{shift: shift_all && ((CNT_W'(i) + CNT_W'(1)) < held_q),
                       load:  load_all && (CNT_W'(i) == load_pos)};
    spq_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl[i]),
      .right_i     (right[i]),
      .load_data_i (load_data),
      .entry_o     (entry[i])
    );
  end

  always_comb begin
    if (mode_q) begin
      adj_sum = {in_i.key[KEY_W-1], in_i.key} - {in_i.amount[KEY_W-1], in_i.amount};
      adj_key = (adj_sum < $signed({2'b11, {(KEY_W-1){1'b0}}}))
                ? {1'b1, {(KEY_W-1){1'b0}}} : adj_sum[KEY_W-1:0];
    end else begin
      adj_sum = {in_i.key[KEY_W-1], in_i.key} + {in_i.amount[KEY_W-1], in_i.amount};
      adj_key = (adj_sum > $signed({2'b00, {(KEY_W-1){1'b1}}}))
                ? {1'b0, {(KEY_W-1){1'b1}}} : adj_sum[KEY_W-1:0];
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d     = state_q;
    held_d      = held_q;
    rem_d       = rem_q;
    ins_d       = ins_q;
    key_d       = key_q;
    nk_d        = nk_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    shift_all   = 1'b0;
    load_all    = 1'b0;
    load_key    = 1'b0;
    load_pos    = held_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          res_d.value  = '0;
          res_d.status = ST_OK;
          res_d.count  = COUNT_W'(held_q);
          state_d      = S_FIN;
          unique case (in_i.command)
            CMD_INSERT: begin
              if (held_q == CNT_W'(CAPACITY)) begin
                res_d.status = ST_FULL;
              end else begin
                key_d   = in_i.key;
                rem_d   = held_q;
                ins_d   = 1'b0;
                state_d = S_INS;
              end
            end
            CMD_DEQUEUE, CMD_PEEK: begin
              if (held_q == '0) begin
                res_d.status = ST_EMPTY;
              end else begin
                res_d.value = head;
                if (in_i.command == CMD_DEQUEUE) begin
                  shift_all   = 1'b1;
                  held_d      = held_q - CNT_W'(1);
                  res_d.count = COUNT_W'(held_q - CNT_W'(1));
                end
              end
            end
            CMD_INC_KEY: begin
              if (in_i.amount[KEY_W-1]) begin
                res_d.status = ST_NEG;
              end else begin
                key_d   = in_i.key;
                nk_d    = adj_key;
                rem_d   = held_q;
                state_d = S_REM;
              end
            end
            default: ;
          endcase
        end
      end
      S_REM: begin
        if (rem_q == '0) begin
          if (held_q == CNT_W'(CAPACITY)) begin
            res_d.value  = '0;
            res_d.status = ST_FULL;
            res_d.count  = COUNT_W'(held_q);
            state_d      = S_FIN;
          end else begin
            key_d   = nk_q;
            rem_d   = held_q;
            ins_d   = 1'b0;
            state_d = S_INS;
          end
        end else begin
          // rotate head to tail, dropping matches
          shift_all = 1'b1;
          rem_d     = rem_q - CNT_W'(1);
          if (head == key_q) begin
            held_d = held_q - CNT_W'(1);
          end else begin
            load_all = 1'b1;
            load_pos = held_q - CNT_W'(1);
          end
        end
      end
      S_INS: begin
        if (rem_q == '0) begin
          if (!ins_q) begin
            load_all = 1'b1;
            load_key = 1'b1;
            load_pos = held_q;
            held_d   = held_q + CNT_W'(1);
          end
          res_d.value  = '0;
          res_d.status = ST_OK;
          res_d.count  = COUNT_W'(held_q + (ins_q ? CNT_W'(0) : CNT_W'(1)));
          state_d      = S_FIN;
        end else if (!ins_q && goes_before(mode_q, key_q, head)) begin
          load_all = 1'b1;
          load_key = 1'b1;
          load_pos = held_q;
          held_d   = held_q + CNT_W'(1);
          ins_d    = 1'b1;
        end else begin
          shift_all = 1'b1;
          load_all  = 1'b1;
          load_pos  = held_q - CNT_W'(1);
          rem_d     = rem_q - CNT_W'(1);
        end
      end
      S_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      held_q      <= '0;
      rem_q       <= '0;
      ins_q       <= 1'b0;
      mode_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      held_q      <= held_d;
      rem_q       <= rem_d;
      ins_q       <= ins_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    nk_q  <= nk_d;
    res_q <= res_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_REM |=> held_q <= $past(held_q))
    else $error("entry count grew during removal pass");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.status != ST_OK |-> out_o.value == '0)
    else $error("nonzero value on error result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.status == ST_EMPTY |-> out_o.count == '0)
    else $error("empty status with nonzero count");

endmodule
